[src/spims_pkg.sv]
// ----------------------------------------------------------------------------
// SPI master request sequencer package
// Item and result types, queue entry and control types, and command codes.
// ----------------------------------------------------------------------------
package spims_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_START   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;

  localparam logic [1:0] CS_NONE    = 2'd0;
  localparam logic [1:0] CS_LOW     = 2'd1;
  localparam logic [1:0] CS_RELEASE = 2'd2;

  localparam logic [1:0] TX_NONE  = 2'd0;
  localparam logic [1:0] TX_BUF   = 2'd1;
  localparam logic [1:0] TX_DUMMY = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  cs_mask;
    logic [15:0] send_len;
    logic [15:0] recv_len;
    logic        hold_cs;
    logic [7:0]  rx_byte;
  } req_item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  cs_action;
    logic [7:0]  cs_out;
    logic [1:0]  tx_kind;
    logic [15:0] tx_index;
    logic        rx_store;
    logic [15:0] rx_index;
    logic [7:0]  rx_data;
    logic        done_res;
    logic        busy_res;
  } res_item_t;

  typedef struct packed {
    logic [7:0]  cs;
    logic [15:0] send_len;
    logic [15:0] recv_len;
    logic        raise;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wr_entry;
  } q_ctrl_t;

  typedef struct packed {
    logic   empty;
    logic   full;
    entry_t front;
  } q_status_t;

endpackage

[src/spims_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spims_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/spims_queue.sv]
// ----------------------------------------------------------------------------
// Request queue
// Counted ring of requests held in RAM, with the front entry always presented.
// ----------------------------------------------------------------------------
module spims_queue #(
  parameter int QUEUE_DEPTH = spims_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  spims_pkg::q_ctrl_t    ctrl,
  output spims_pkg::q_status_t  status
);

  import spims_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0] head, head_next, tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic             byp_valid;
  entry_t           byp_data;
  logic [$bits(entry_t)-1:0] ram_rd;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (ctrl.pop) begin
      head_next  = (head == LAST) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end
    if (ctrl.push) begin
      tail_next  = (tail == LAST) ? '0 : tail + 1'b1;
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      byp_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      // A write into the slot about to become the front is not yet visible
      // through the RAM read port, so it is forwarded for one cycle.
      byp_valid <= ctrl.push && (tail == head_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= ctrl.wr_entry;
  end

  spims_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctrl.push),
    .wr_addr (tail),
    .wr_data (ctrl.wr_entry),
    .rd_addr (head_next),
    .rd_data (ram_rd)
  );

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.front = byp_valid ? byp_data : entry_t'(ram_rd);

endmodule

[src/spims_xfer.sv]
// ----------------------------------------------------------------------------
// Transfer sequencer
// Decodes one item, tracks byte counts of the front request, builds the result.
// ----------------------------------------------------------------------------
module spims_xfer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  spims_pkg::req_item_t  item,
  input  spims_pkg::q_status_t  qstat,
  output spims_pkg::q_ctrl_t    qctrl,
  output spims_pkg::res_item_t  result
);

  import spims_pkg::*;

  logic [15:0] sent_count, sent_next;
  logic [15:0] recv_count, recv_next;
  logic        active, active_next;

  always_comb begin
    result      = '0;
    qctrl       = '0;
    sent_next   = sent_count;
    recv_next   = recv_count;
    active_next = active;

    qctrl.wr_entry.cs       = item.cs_mask;
    qctrl.wr_entry.send_len = item.send_len;
    qctrl.wr_entry.recv_len = item.recv_len;
    qctrl.wr_entry.raise    = ~item.hold_cs;

    case (item.mode)
      MODE_ENQUEUE: begin
        if (!qstat.full) begin
          qctrl.push      = take;
          result.accepted = 1'b1;
        end
      end
      MODE_START: begin
        if (!qstat.empty) begin
          result.accepted  = 1'b1;
          result.cs_action = CS_LOW;
          result.cs_out    = qstat.front.cs;
          recv_next        = '0;
          active_next      = 1'b1;
          // With nothing to send a dummy byte still clocks the bus.
          if (qstat.front.send_len != '0) begin
            result.tx_kind = TX_BUF;
            sent_next      = 16'd1;
          end else begin
            result.tx_kind = TX_DUMMY;
            sent_next      = '0;
          end
        end
      end
      MODE_BYTE: begin
        if (active) begin
          if (recv_count < qstat.front.recv_len) begin
            result.rx_store = 1'b1;
            result.rx_index = recv_count;
            result.rx_data  = item.rx_byte;
            recv_next       = recv_count + 1'b1;
          end
          if (sent_count < qstat.front.send_len) begin
            result.tx_kind  = TX_BUF;
            result.tx_index = sent_count;
            sent_next       = sent_count + 1'b1;
          end else if (recv_next < qstat.front.recv_len) begin
            result.tx_kind = TX_DUMMY;
          end
          if (sent_next >= qstat.front.send_len && recv_next >= qstat.front.recv_len) begin
            if (qstat.front.raise) begin
              result.cs_action = CS_RELEASE;
              result.cs_out    = qstat.front.cs;
            end
            result.done_res = 1'b1;
            qctrl.pop       = take;
            active_next     = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    result.busy_res = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_count <= '0;
      recv_count <= '0;
      active     <= 1'b0;
    end else if (take) begin
      sent_count <= sent_next;
      recv_count <= recv_next;
      active     <= active_next;
    end
  end

endmodule

[src/spi_master_request_sequencer.sv]
// ----------------------------------------------------------------------------
// SPI master request sequencer
// Queues SPI transactions and steps the front one through its bytes.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and returns exactly one result for
// each, registered when the transaction is taken; a new item is let
// in while the output register is empty or in the cycle its result is taken,
// and is held off while a result waits. Requests sit in a QUEUE_DEPTH-entry
// RAM read at the next head pointer through its single read port. Queue slots
// need no clearing after reset, so the block is ready from the first cycle out
// of reset.
// Buffer data stays outside; only indices, the chip-select mask, the received
// byte and control flags are given out.
module spi_master_request_sequencer #(
  parameter int QUEUE_DEPTH = spims_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spims_pkg::req_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spims_pkg::res_item_t  out_data
);

  import spims_pkg::*;

  logic      take;
  q_ctrl_t   qctrl;
  q_status_t qstat;
  res_item_t result;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  spims_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (qctrl),
    .status (qstat)
  );

  spims_xfer u_xfer (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (in_data),
    .qstat  (qstat),
    .qctrl  (qctrl),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

endmodule
